@@ hw/rtl/fpws_pkg.sv @@
// Package for frame_period_window_stats: widths, constants and the sequencer
// state type used by the top level.
// No dependencies.
package fpws_pkg;

  // Default ring depth in periods
  localparam int WINDOW_DEF = 100;

  // Field widths fixed by the interface
  localparam int TS_W  = 32;
  localparam int MIN_W = 17;

  // Starting point of the minimum search; results are capped here
  localparam logic [MIN_W-1:0] MIN_START = 17'd100000;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/fpws_div.sv @@
// Restoring divider for frame_period_window_stats: one quotient bit a cycle.
// Depends on nothing outside this file.
module fpws_div #(
  parameter int SUM_W = 39,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // Control: busy until the step count runs out, done pulses once at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the remainder when the trial subtraction does not borrow
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/frame_period_window_stats.sv @@
// Frame period window statistics: ring of the last WINDOW frame periods.
// After an item is accepted, the ring is scanned, the sum is divided by the fill
// count and the result is loaded into the output register.
// One item at a time: the next item is taken the cycle after the result is
// loaded into the output register, which waits while a held result is unaccepted.
// Reset (synchronous, active high): disabled, unprimed, ring counted empty.
module frame_period_window_stats #(
  parameter int WINDOW = fpws_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fpws_pkg::TS_W-1:0]   timestamp_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fpws_pkg::TS_W-1:0]   last_period,
  output logic [fpws_pkg::MIN_W-1:0]  min_period,
  output logic [fpws_pkg::TS_W-1:0]   max_period,
  output logic [fpws_pkg::TS_W-1:0]   mean_period,
  output logic                        window_end
);

  localparam int TS_W  = fpws_pkg::TS_W;
  localparam int MIN_W = fpws_pkg::MIN_W;
  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = TS_W + CW;

  fpws_pkg::state_t state, state_next;

  logic             enable;
  logic             primed;
  logic [TS_W-1:0]  prev_ts;
  logic [AW-1:0]    write_slot;
  logic [CW-1:0]    filled;
  logic [TS_W-1:0]  period;
  logic             wrapped;

  logic [TS_W-1:0]  ring [WINDOW];
  logic [CW-1:0]    rd_addr;
  logic             rd_pend;
  logic [TS_W-1:0]  rd_data;

  logic [MIN_W-1:0] lo;
  logic [TS_W-1:0]  hi;
  logic [SUM_W-1:0] sum;

  logic             in_fire;
  logic             take;
  logic [TS_W-1:0]  new_period;
  logic             slot_last;
  logic             rd_issue;
  logic             scan_end;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic             out_load;

  assign in_fire    = in_valid && in_ready;
  assign take       = in_fire && primed && enable;
  assign new_period = timestamp_ms - prev_ts;
  assign slot_last  = (write_slot == AW'(WINDOW - 1));
  assign scan_end   = (rd_addr == filled) && !rd_pend;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fpws_pkg::ST_IDLE: if (take) state_next = fpws_pkg::ST_SCAN;
      fpws_pkg::ST_SCAN: if (scan_end) state_next = fpws_pkg::ST_DIV;
      fpws_pkg::ST_DIV:  if (div_done) state_next = fpws_pkg::ST_DONE;
      fpws_pkg::ST_DONE: if (!out_valid || out_ready) state_next = fpws_pkg::ST_IDLE;
      default:           state_next = fpws_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      fpws_pkg::ST_IDLE: in_ready = 1'b1;
      fpws_pkg::ST_SCAN: begin
        rd_issue  = (rd_addr != filled);
        div_start = scan_end;
      end
      fpws_pkg::ST_DIV:  ;
      fpws_pkg::ST_DONE: out_load = !out_valid || out_ready;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_wr_en) begin
      enable <= cfg_wr_data;
    end
  end

  // Timestamp history, ring position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      prev_ts    <= '0;
      write_slot <= '0;
      filled     <= '0;
    end else if (in_fire) begin
      primed  <= 1'b1;
      prev_ts <= timestamp_ms;
      if (take) begin
        write_slot <= slot_last ? '0 : write_slot + 1'b1;
        if (filled != CW'(WINDOW)) begin
          filled <= filled + 1'b1;
        end
      end
    end
  end

  // Hold the newest period and wrap flag for the result
  always_ff @(posedge clk) begin
    if (take) begin
      period  <= new_period;
      wrapped <= slot_last;
    end
  end

  // Ring memory: write on accept, registered read during the scan
  always_ff @(posedge clk) begin
    if (take) begin
      ring[write_slot] <= new_period;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr[AW-1:0]];
  end

  // Scan address and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (take) begin
        rd_addr <= '0;
      end else if (rd_issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
      rd_pend <= rd_issue;
    end
  end

  // Accumulate minimum, maximum and sum as read data arrives
  always_ff @(posedge clk) begin
    if (take) begin
      lo  <= fpws_pkg::MIN_START;
      hi  <= '0;
      sum <= '0;
    end else if (rd_pend) begin
      if (rd_data < {{(TS_W - MIN_W){1'b0}}, lo}) begin
        lo <= rd_data[MIN_W-1:0];
      end
      if (rd_data > hi) begin
        hi <= rd_data;
      end
      sum <= sum + SUM_W'(rd_data);
    end
  end

  // Mean: sum over fill count
  fpws_div #(
    .SUM_W (SUM_W),
    .CNT_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (filled),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      last_period <= period;
      min_period  <= lo;
      max_period  <= hi;
      mean_period <= div_quo[TS_W-1:0];
      window_end  <= wrapped;
    end
  end

`ifndef SYNTHESIS
  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CW'(WINDOW))
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= AW'(WINDOW - 1))
    else $error("write slot beyond window");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == fpws_pkg::ST_SCAN)
    else $error("ring read outside scan");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == fpws_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result load lost");
`endif

endmodule
